@@ design/i2cmts_pkg.sv @@
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; used by every module of the block and by the checker.
`timescale 1ns / 1ps

package i2cmts_pkg;

  // Event kinds on the input channel (in_tuser)
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_BYTE_DONE = 3'd1;
  localparam logic [2:0] REQ_BYTE_RECV = 3'd2;
  localparam logic [2:0] REQ_BUS_ERROR = 3'd3;
  localparam logic [2:0] REQ_TIMEOUT = 3'd4;

  // Bus commands (out_tuser)
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_SEND_ADDR = 3'd1;
  localparam logic [2:0] CMD_SEND_DATA = 3'd2;
  localparam logic [2:0] CMD_ACK_NEXT = 3'd3;
  localparam logic [2:0] CMD_NACK_STOP = 3'd4;
  localparam logic [2:0] CMD_STOP = 3'd5;
  localparam logic [2:0] CMD_STOP_ADDR = 3'd6;

  // Timer actions
  localparam logic [1:0] TMR_KEEP = 2'd0;
  localparam logic [1:0] TMR_ARM = 2'd1;
  localparam logic [1:0] TMR_CANCEL = 2'd2;

  // Status codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BUSY = 3'd1;
  localparam logic [2:0] ST_OK = 3'd2;
  localparam logic [2:0] ST_ERR = 3'd3;
  localparam logic [2:0] ST_TMO = 3'd4;

  // Transaction phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT_MS = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  localparam logic [3:0] TIMEOUT_LIMIT_RST = 4'd5;
  localparam logic [3:0] TIMEOUT_CNT_MAX = 4'd15;

  // Longest write or read run; longer requests are clipped on start
  localparam logic [7:0] MAX_LENGTH = 8'd255;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] target_address;
    logic [7:0] write_length;
    logic [7:0] read_length;
    logic       stop_before_read;
    logic       nack_seen;
    logic [7:0] next_write_byte;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       store_read_byte;
    logic [1:0] timer_action;
    logic [2:0] status_code;
    logic       done_flag;
    logic       bus_reset_request;
    logic       start_accepted;
  } res_t;

  function automatic logic [7:0] clamp_len(input logic [7:0] v);
    return (v > MAX_LENGTH) ? MAX_LENGTH : v;
  endfunction

endpackage

@@ design/i2c_master_transaction_sequencer_top.sv @@
// Top level of the I2C master transaction sequencer: stream ports, field packing.
// Depends on i2cmts_pkg, i2cmts_core and i2cmts_skid.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------
//  in_      | in  | in_tvalid/in_tready   | tuser: event kind; tdata: request
//  out_     | out | out_tvalid/out_tready | tuser: bus command; tdata: result
//  cfg_     | in  | cfg_we                | cfg_addr selects, cfg_wdata value
//
//  Each event yields exactly one result, registered on its transfer. One event
//  per cycle is sustained unless the output stalls; the next-state logic of the
//  core is the only path, a single pass from the sequencer registers to the
//  result register. A stalled output holds one result in the result register
//  and one in a skid entry; in_tready drops only while the skid entry is full.
//  Reset (rst_n low, synchronous) returns to idle with timeout limit 5.
//  Register 0 (timeout in ms) is taken but has no effect here: the duration
//  belongs to the external timer, which only sees arm and cancel.

module i2c_master_transaction_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  // target_address[6:0], write_length[14:7], read_length[22:15],
  // stop_before_read[23], nack_seen[24], next_write_byte[32:25],
  // received_byte[40:33], zero pad[47:41]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bus_command[2:0]
  output logic [2:0]  out_tuser,
  // address_byte[7:0], data_byte[15:8], byte_index[23:16],
  // store_read_byte[24], timer_action[26:25], status_code[29:27],
  // done_flag[30], bus_reset_request[31], start_accepted[32], zero pad[39:33]
  output logic [39:0] out_tdata
);

  i2cmts_pkg::item_t item;
  i2cmts_pkg::res_t  core_res;
  i2cmts_pkg::res_t  out_res;
  logic              item_acc;

  assign item_acc = in_tvalid && in_tready;

  assign item.req_type         = in_tuser;
  assign item.target_address   = in_tdata[6:0];
  assign item.write_length     = in_tdata[14:7];
  assign item.read_length      = in_tdata[22:15];
  assign item.stop_before_read = in_tdata[23];
  assign item.nack_seen        = in_tdata[24];
  assign item.next_write_byte  = in_tdata[32:25];
  assign item.received_byte    = in_tdata[40:33];

  i2cmts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item_acc  (item_acc),
    .item      (item),
    .res       (core_res)
  );

  i2cmts_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_data (core_res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.bus_command;
  assign out_tdata = {7'd0,
                      out_res.start_accepted,
                      out_res.bus_reset_request,
                      out_res.done_flag,
                      out_res.status_code,
                      out_res.timer_action,
                      out_res.store_read_byte,
                      out_res.byte_index,
                      out_res.data_byte,
                      out_res.address_byte};

endmodule

@@ design/i2cmts_core.sv @@
// Transaction state and next-result logic: one event in, one result out.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps

module i2cmts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_wdata,
  input  logic                item_acc,
  input  i2cmts_pkg::item_t   item,
  output i2cmts_pkg::res_t    res
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] byte_cnt_r, byte_cnt_nxt;
  logic [3:0] tmo_cnt_r, tmo_cnt_nxt;
  logic [2:0] last_status_r, last_status_nxt;
  logic [6:0] saddr_r, saddr_nxt;
  logic [7:0] swlen_r, swlen_nxt;
  logic [7:0] srlen_r, srlen_nxt;
  logic       sstop_r, sstop_nxt;
  logic [3:0] tmo_limit_r;

  logic [7:0] wlen_c, rlen_c, cnt_inc;
  logic [3:0] tmo_inc;

  // Only the limit is kept here; the timer itself holds its own duration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_limit_r <= i2cmts_pkg::TIMEOUT_LIMIT_RST;
    end else if (cfg_we && cfg_addr == i2cmts_pkg::CFG_TIMEOUT_LIMIT) begin
      tmo_limit_r <= cfg_wdata[3:0];
    end
  end

  always_comb begin
    wlen_c  = i2cmts_pkg::clamp_len(item.write_length);
    rlen_c  = i2cmts_pkg::clamp_len(item.read_length);
    cnt_inc = byte_cnt_r + 8'd1;
    tmo_inc = (tmo_cnt_r != i2cmts_pkg::TIMEOUT_CNT_MAX) ? tmo_cnt_r + 4'd1 : tmo_cnt_r;

    phase_nxt       = phase_r;
    byte_cnt_nxt    = byte_cnt_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    last_status_nxt = last_status_r;
    saddr_nxt       = saddr_r;
    swlen_nxt       = swlen_r;
    srlen_nxt       = srlen_r;
    sstop_nxt       = sstop_r;
    res             = '0;

    if (item.req_type == i2cmts_pkg::REQ_START) begin
      if (phase_r == i2cmts_pkg::PH_IDLE) begin
        res.start_accepted = 1'b1;
        if (last_status_r != i2cmts_pkg::ST_TMO) begin
          tmo_cnt_nxt = '0;
        end
        saddr_nxt       = item.target_address;
        swlen_nxt       = wlen_c;
        srlen_nxt       = rlen_c;
        sstop_nxt       = item.stop_before_read;
        last_status_nxt = i2cmts_pkg::ST_BUSY;
        byte_cnt_nxt    = '0;
        if (wlen_c != 8'd0) begin
          phase_nxt          = i2cmts_pkg::PH_WRITE;
          res.bus_command    = i2cmts_pkg::CMD_SEND_ADDR;
          res.address_byte   = {item.target_address, 1'b0};
          res.timer_action   = i2cmts_pkg::TMR_ARM;
        end else if (rlen_c != 8'd0) begin
          phase_nxt          = i2cmts_pkg::PH_READ;
          res.bus_command    = i2cmts_pkg::CMD_SEND_ADDR;
          res.address_byte   = {item.target_address, 1'b1};
          res.timer_action   = i2cmts_pkg::TMR_ARM;
        end else begin
          // nothing to move: done at once
          phase_nxt          = i2cmts_pkg::PH_IDLE;
          last_status_nxt    = i2cmts_pkg::ST_OK;
          res.done_flag      = 1'b1;
        end
      end
    end else if (phase_r != i2cmts_pkg::PH_IDLE) begin
      case (item.req_type)
        i2cmts_pkg::REQ_BYTE_DONE: begin
          if (item.nack_seen) begin
            res.bus_command  = i2cmts_pkg::CMD_STOP;
            res.timer_action = i2cmts_pkg::TMR_CANCEL;
            res.done_flag    = 1'b1;
            phase_nxt        = i2cmts_pkg::PH_IDLE;
            last_status_nxt  = i2cmts_pkg::ST_ERR;
          end else if (phase_r == i2cmts_pkg::PH_WRITE) begin
            if (byte_cnt_r < swlen_r) begin
              res.bus_command  = i2cmts_pkg::CMD_SEND_DATA;
              res.data_byte    = item.next_write_byte;
              res.byte_index   = byte_cnt_r;
              res.timer_action = i2cmts_pkg::TMR_ARM;
              byte_cnt_nxt     = cnt_inc;
            end else if (srlen_r != 8'd0) begin
              res.bus_command  = sstop_r ? i2cmts_pkg::CMD_STOP_ADDR
                                         : i2cmts_pkg::CMD_SEND_ADDR;
              res.address_byte = {saddr_r, 1'b1};
              res.timer_action = i2cmts_pkg::TMR_ARM;
              byte_cnt_nxt     = '0;
              phase_nxt        = i2cmts_pkg::PH_READ;
            end else begin
              res.bus_command  = i2cmts_pkg::CMD_STOP;
              res.timer_action = i2cmts_pkg::TMR_CANCEL;
              res.done_flag    = 1'b1;
              phase_nxt        = i2cmts_pkg::PH_IDLE;
              last_status_nxt  = i2cmts_pkg::ST_OK;
            end
          end
        end
        i2cmts_pkg::REQ_BYTE_RECV: begin
          if (phase_r == i2cmts_pkg::PH_READ) begin
            res.data_byte       = item.received_byte;
            res.byte_index      = byte_cnt_r;
            res.store_read_byte = 1'b1;
            byte_cnt_nxt        = cnt_inc;
            if (cnt_inc < srlen_r) begin
              res.bus_command  = i2cmts_pkg::CMD_ACK_NEXT;
              res.timer_action = i2cmts_pkg::TMR_ARM;
            end else begin
              res.bus_command  = i2cmts_pkg::CMD_NACK_STOP;
              res.timer_action = i2cmts_pkg::TMR_CANCEL;
              res.done_flag    = 1'b1;
              phase_nxt        = i2cmts_pkg::PH_IDLE;
              last_status_nxt  = i2cmts_pkg::ST_OK;
            end
          end
        end
        i2cmts_pkg::REQ_BUS_ERROR: begin
          res.bus_command  = i2cmts_pkg::CMD_STOP;
          res.timer_action = i2cmts_pkg::TMR_CANCEL;
          res.done_flag    = 1'b1;
          phase_nxt        = i2cmts_pkg::PH_IDLE;
          last_status_nxt  = i2cmts_pkg::ST_ERR;
        end
        i2cmts_pkg::REQ_TIMEOUT: begin
          // timer already fired: leave it alone
          if (tmo_inc >= tmo_limit_r) begin
            res.bus_reset_request = 1'b1;
            tmo_cnt_nxt           = '0;
          end else begin
            tmo_cnt_nxt = tmo_inc;
          end
          res.done_flag   = 1'b1;
          phase_nxt       = i2cmts_pkg::PH_IDLE;
          last_status_nxt = i2cmts_pkg::ST_TMO;
        end
        default: begin
          // unknown event kind: no effect
        end
      endcase
    end

    res.status_code = last_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= i2cmts_pkg::PH_IDLE;
      byte_cnt_r    <= '0;
      tmo_cnt_r     <= '0;
      last_status_r <= i2cmts_pkg::ST_IDLE;
      saddr_r       <= '0;
      swlen_r       <= '0;
      srlen_r       <= '0;
      sstop_r       <= 1'b0;
    end else if (item_acc) begin
      phase_r       <= phase_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
      last_status_r <= last_status_nxt;
      saddr_r       <= saddr_nxt;
      swlen_r       <= swlen_nxt;
      srlen_r       <= srlen_nxt;
      sstop_r       <= sstop_nxt;
    end
  end

endmodule

@@ design/i2cmts_skid.sv @@
// Result register with a skid entry; registers ready toward the core side.
// Depends on i2cmts_pkg.
`timescale 1ns / 1ps

module i2cmts_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cmts_pkg::res_t  push_data,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cmts_pkg::res_t  out_data
);

  logic             main_vld_r, main_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  i2cmts_pkg::res_t main_r, main_nxt;
  i2cmts_pkg::res_t skid_r, skid_nxt;
  logic             pop;

  assign pop       = main_vld_r && out_ready;
  assign ready     = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ design/i2cmts_chk.sv @@
// Port-level checker for the sequencer top, attached by bind.
// Depends on i2cmts_pkg and i2c_master_transaction_sequencer_top.
`timescale 1ns / 1ps

module i2cmts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [39:0] out_tdata
);

  logic [2:0] status;
  assign status = out_tdata[29:27];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a finished transaction reports a final status
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30] |->
      status == i2cmts_pkg::ST_OK || status == i2cmts_pkg::ST_ERR ||
      status == i2cmts_pkg::ST_TMO)
    else $error("done without final status");

  // an accepted start leaves the block busy, or done at once
  a_start_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |->
      (status == i2cmts_pkg::ST_BUSY && !out_tdata[30]) ||
      (status == i2cmts_pkg::ST_OK && out_tdata[30]))
    else $error("bad status on accepted start");

  // bus reset only comes with a timeout finish and no bus command
  a_reset_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |->
      status == i2cmts_pkg::ST_TMO && out_tdata[30] &&
      out_tuser == i2cmts_pkg::CMD_NONE)
    else $error("bus reset outside timeout");

  // stored read bytes go with read-phase commands only
  a_store_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |->
      out_tuser == i2cmts_pkg::CMD_ACK_NEXT || out_tuser == i2cmts_pkg::CMD_NACK_STOP)
    else $error("read byte store with wrong command");

endmodule

bind i2c_master_transaction_sequencer_top i2cmts_chk u_i2cmts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
